// ===== design/pressure_temp_compensation_core_macros.svh =====
// Assertion helpers used by the compensation core.
`ifndef PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is held.
`define PTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PTC_NEVER(label, cond, msg) \
    `PTC_ASSERT(label, !(cond), msg)

`endif

// ===== design/ptc_pkg.sv =====
`timescale 1ns / 1ps

package ptc_pkg;

    // Depth of each pipelined divider, one quotient bit per stage.
    localparam int DivBits = 32;

    localparam logic [31:0] TempOffset = 32'd4000;
    localparam logic [31:0] B4Bias     = 32'd32768;
    localparam logic [31:0] B7Scale    = 32'd50000;
    localparam logic [31:0] SignBit    = 32'h8000_0000;
    localparam logic [31:0] PolyC1     = 32'd3038;
    localparam logic [31:0] PolyC2     = 32'hFFFF_E343;
    localparam logic [31:0] PolyC3     = 32'd3791;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } ptc_cfg_idx_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } ptc_in_t;

    typedef struct packed {
        logic signed [12:0] temperature_tenths;
        logic [17:0]        pressure_pa;
        logic               invalid;
    } ptc_out_t;

    // Working values that travel with an item down the pipeline.
    typedef struct packed {
        logic [18:0] up;
        logic [12:0] temp;
        logic        inv;
        logic        neg;
        logic        dbl;
        logic [31:0] x1;
        logic [31:0] b6;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } ptc_side_t;

    // Arithmetic right shift of a 32-bit two's complement word.
    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

    // Sign extension of a 16-bit field.
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// ===== design/ptc_udiv32.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, with sideband.
module ptc_udiv32
    import ptc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_vld,
    input  ptc_side_t   in_side,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        out_vld,
    output ptc_side_t   out_side,
    output logic [31:0] quo
);

    logic        vld_reg  [DivBits];
    ptc_side_t   side_reg [DivBits];
    logic [31:0] rem_reg  [DivBits];
    logic [31:0] nq_reg   [DivBits];
    logic [31:0] den_reg  [DivBits];

    for (genvar k = 0; k < DivBits; k++) begin : g_stage
        logic        vld_in;
        ptc_side_t   side_in;
        logic [31:0] rem_in;
        logic [31:0] nq_in;
        logic [31:0] den_in;
        logic [32:0] sh;
        logic        ge;
        logic [31:0] rem_next;
        logic [31:0] nq_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_vld;
            assign side_in = in_side;
            assign rem_in  = '0;
            assign nq_in   = num;
            assign den_in  = den;
        end else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign den_in  = den_reg[k-1];
        end

        // Shift in the next dividend bit and try a subtraction.
        always_comb begin
            sh       = {rem_in, nq_in[31]};
            ge       = (sh >= {1'b0, den_in});
            rem_next = ge ? 32'(sh - {1'b0, den_in}) : sh[31:0];
            nq_next  = {nq_in[30:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
            if (en) begin
                side_reg[k] <= side_in;
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
                den_reg[k]  <= den_in;
            end
        end
    end

    assign out_vld  = vld_reg[DivBits-1];
    assign out_side = side_reg[DivBits-1];
    assign quo      = nq_reg[DivBits-1];

endmodule

// ===== design/pressure_temp_compensation_core.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; two 32-stage dividers set the depth.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (aresetn low, synchronous) clears all valid bits and sets the
// coefficients to zero and the oversampling setting to one.
module pressure_temp_compensation_core
    import ptc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ptc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ptc_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "pressure_temp_compensation_core_macros.svh"

    logic [31:0] ac1_ac2_reg, ac3_ac4_reg, ac5_ac6_reg, b1_b2_reg, mc_md_reg;
    logic [1:0]  oss_reg;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    logic        en;
    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic        v8_reg, v9_reg, v10_reg;
    ptc_side_t   s0_reg, s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    ptc_side_t   s8_reg, s9_reg, s10_reg;
    ptc_side_t   s0_next, s1_next, s2_next, s3_next, s4_next, s5_next;
    ptc_side_t   s6_next, s8_next, s9_next, s10_next;

    ptc_side_t   da_side, da_out_side, db_side, db_out_side;
    logic [31:0] da_num, da_den, da_quo, db_num, db_den, db_quo;
    logic        da_out_vld, db_out_vld;

    logic        out_vld_reg;
    ptc_out_t    out_reg, out_next;
    logic        out_fields_zero;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac1_ac2_reg <= '0;
            ac3_ac4_reg <= '0;
            ac5_ac6_reg <= '0;
            b1_b2_reg   <= '0;
            mc_md_reg   <= '0;
            oss_reg     <= 2'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_AC1_AC2: ac1_ac2_reg <= cfg_data;
                CFG_AC3_AC4: ac3_ac4_reg <= cfg_data;
                CFG_AC5_AC6: ac5_ac6_reg <= cfg_data;
                CFG_B1_B2:   b1_b2_reg   <= cfg_data;
                CFG_MC_MD:   mc_md_reg   <= cfg_data;
                CFG_OSS:     oss_reg     <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    // Coefficients widened to 32-bit words.
    assign ac1 = sx16(ac1_ac2_reg[31:16]);
    assign ac2 = sx16(ac1_ac2_reg[15:0]);
    assign ac3 = sx16(ac3_ac4_reg[31:16]);
    assign ac4 = {16'd0, ac3_ac4_reg[15:0]};
    assign ac5 = {16'd0, ac5_ac6_reg[31:16]};
    assign ac6 = {16'd0, ac5_ac6_reg[15:0]};
    assign b1  = sx16(b1_b2_reg[31:16]);
    assign b2  = sx16(b1_b2_reg[15:0]);
    assign mc  = sx16(mc_md_reg[31:16]);
    assign md  = sx16(mc_md_reg[15:0]);

    // The whole pipeline moves unless a finished item is held at the output.
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // Stage 0 captures the raw words; stage 1 forms the temperature product.
    always_comb begin
        s0_next    = '0;
        s0_next.a  = {16'd0, s_data.raw_temperature};
        s0_next.up = s_data.raw_pressure;

        s1_next   = s0_reg;
        s1_next.a = (s0_reg.a - ac6) * ac5;
    end

    // Divider A input: MC*2048 over X1+MD, by magnitudes.
    always_comb begin
        logic [31:0] x1;
        logic [31:0] dv;
        logic [31:0] n;
        x1          = asr32(s1_reg.a, 5'd15);
        dv          = x1 + md;
        n           = mc << 11;
        da_side     = s1_reg;
        da_side.x1  = x1;
        da_side.inv = (dv == '0);
        da_side.neg = n[31] ^ dv[31];
        da_num      = n[31] ? 32'(0 - n) : n;
        da_den      = dv[31] ? 32'(0 - dv) : dv;
    end

    ptc_udiv32 u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v1_reg),
        .in_side  (da_side),
        .num      (da_num),
        .den      (da_den),
        .out_vld  (da_out_vld),
        .out_side (da_out_side),
        .quo      (da_quo)
    );

    // Stages 2 to 6: temperature, B6 terms, B3, B4 and B7 products.
    always_comb begin
        logic [31:0] x2;
        logic [31:0] b5;
        logic [31:0] t;
        logic [31:0] sq;
        logic [31:0] x3;
        logic [31:0] b3;
        logic [31:0] x3b;

        // Temperature from B5, saturated to the field.
        x2      = da_out_side.neg ? 32'(0 - da_quo) : da_quo;
        b5      = da_out_side.x1 + x2;
        t       = asr32(b5 + 32'd8, 5'd4);
        s2_next = da_out_side;
        s2_next.b6 = b5 - TempOffset;
        if ($signed(t) < -32'sd4096) begin
            s2_next.temp = 13'h1000;
        end else if ($signed(t) > 32'sd4095) begin
            s2_next.temp = 13'h0FFF;
        end else begin
            s2_next.temp = t[12:0];
        end

        s3_next   = s2_reg;
        s3_next.a = s2_reg.b6 * s2_reg.b6;

        sq        = asr32(s3_reg.a, 5'd12);
        s4_next   = s3_reg;
        s4_next.a = b2 * sq;
        s4_next.b = ac2 * s3_reg.b6;
        s4_next.c = ac3 * s3_reg.b6;
        s4_next.d = b1 * sq;

        x3        = asr32(s4_reg.a, 5'd11) + asr32(s4_reg.b, 5'd11);
        b3        = asr32(((ac1 << 2) + x3 << oss_reg) + 32'd2, 5'd2);
        x3b       = asr32(asr32(s4_reg.c, 5'd13) + asr32(s4_reg.d, 5'd16) + 32'd2, 5'd2);
        s5_next   = s4_reg;
        s5_next.a = b3;
        s5_next.b = x3b;

        s6_next   = s5_reg;
        s6_next.a = ac4 * (s5_reg.b + B4Bias);
        s6_next.b = ({13'd0, s5_reg.up} - s5_reg.a) * (B7Scale >> oss_reg);
    end

    // Divider B input: B7 (doubled when it fits) over B4.
    always_comb begin
        logic [31:0] b4;
        b4          = s6_reg.a >> 15;
        db_side     = s6_reg;
        db_side.inv = s6_reg.inv || (b4 == '0);
        db_side.dbl = (s6_reg.b < SignBit);
        db_num      = db_side.dbl ? (s6_reg.b << 1) : s6_reg.b;
        db_den      = b4;
    end

    ptc_udiv32 u_div_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v6_reg),
        .in_side  (db_side),
        .num      (db_num),
        .den      (db_den),
        .out_vld  (db_out_vld),
        .out_side (db_out_side),
        .quo      (db_quo)
    );

    // Stages 8 to 10: pressure correction polynomial.
    always_comb begin
        logic [31:0] pa;
        s8_next   = db_out_side;
        s8_next.a = db_out_side.dbl ? db_quo : (db_quo << 1);

        pa        = asr32(s8_reg.a, 5'd8);
        s9_next   = s8_reg;
        s9_next.b = pa * pa;
        s9_next.c = PolyC2 * s8_reg.a;

        s10_next   = s9_reg;
        s10_next.b = s9_reg.b * PolyC1;
    end

    // Output stage: final sum, saturation and the invalid case.
    always_comb begin
        logic [31:0] pf;
        pf = s10_reg.a + asr32(asr32(s10_reg.b, 5'd16) + asr32(s10_reg.c, 5'd16) + PolyC3,
                               5'd4);
        out_next = '0;
        if (s10_reg.inv) begin
            out_next.invalid = 1'b1;
        end else begin
            out_next.temperature_tenths = s10_reg.temp;
            if (pf[31]) begin
                out_next.pressure_pa = '0;
            end else if (pf > 32'd262143) begin
                out_next.pressure_pa = '1;
            end else begin
                out_next.pressure_pa = pf[17:0];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            v10_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= s_valid;
            v1_reg      <= v0_reg;
            v2_reg      <= da_out_vld;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v8_reg      <= db_out_vld;
            v9_reg      <= v8_reg;
            v10_reg     <= v9_reg;
            out_vld_reg <= v10_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg  <= s0_next;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            s6_reg  <= s6_next;
            s8_reg  <= s8_next;
            s9_reg  <= s9_next;
            s10_reg <= s10_next;
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    assign out_fields_zero = (m_data.temperature_tenths == '0) && (m_data.pressure_pa == '0);

    // An invalid item carries zero readings.
    `PTC_ASSERT(a_invalid_zero, m_valid && m_data.invalid |-> out_fields_zero, "invalid item with data")
    // A held result stalls the input side.
    `PTC_NEVER(a_stall_back, m_valid && !m_ready && s_ready, "input ready during stall")
    // A stalled result stays put for the next cycle.
    `PTC_ASSERT(a_hold_out, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

endmodule
